[rtl/stf_pkg.sv]
package stf_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_W       = 32;

  // Fixed field widths of the channels
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned TOTAL_W  = 5;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [TOTAL_W-1:0]  entry_total;
  } stf_rsp_t;

  typedef struct packed {
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [KEY_W-1:0] wdata;
    logic                    re;
    logic [IDX_W-1:0]        raddr;
  } stf_mem_cmd_t;

endpackage

[rtl/stf_if.sv]
interface stf_req_if;
  import stf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [KEY_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface stf_rsp_if;
  import stf_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [TOTAL_W-1:0]  entry_total;

  modport source (output valid, output status, output position, output entry_total,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_total,
                  output ready);
endinterface

[rtl/sorted_table_insert_find_delete.sv]
// Channel  Dir  Fields                                   Request accepted when
// req_i    in   kind[1:0], value[31:0] signed             req_i.valid && req_i.ready
// rsp_o    out  status[1:0], position[3:0], entry_total[4:0]  rsp_o.valid && rsp_o.ready
//
// One request is worked on at a time; the single-port-write table RAM sets the pace.
// Insert: reads the last entry, shifts each larger entry right one by one, then writes the key.
// Find: a binary search; each probe reads the middle entry, then compares it with the key.
// Delete: the find, then the entries after the hit are shifted left one by one.
// Response adds one register stage; a new request is taken while it waits.
// Reset clears the fill count and the controller state; table contents are not cleared.
module sorted_table_insert_find_delete (
  input  logic     clk_i,
  input  logic     rst_ni,
  stf_req_if.sink  req_i,
  stf_rsp_if.source rsp_o
);
  import stf_pkg::*;

  // Controller to output stage
  logic                    res_valid;
  logic                    res_ready;
  stf_rsp_t                res;

  // Table RAM port
  stf_mem_cmd_t            mem_cmd;
  logic [KEY_W-1:0]        mem_rdata;

  // Output register
  logic                    out_valid_q;
  stf_rsp_t                out_q;

  stf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_kind_i  (req_i.kind),
    .req_value_i (req_i.value),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem_cmd),
    .mem_rdata_i ($signed(mem_rdata))
  );

  // Sorted keys, one per entry; read data appears the cycle after the address
  stf_ram #(
    .Depth (TABLE_DEPTH),
    .Width (KEY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_cmd.we),
    .waddr_i (mem_cmd.waddr),
    .wdata_i (mem_cmd.wdata),
    .re_i    (mem_cmd.re),
    .raddr_i (mem_cmd.raddr),
    .rdata_o (mem_rdata)
  );

  // Output stage: load when empty or being drained this cycle
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.position    = out_q.position;
  assign rsp_o.entry_total = out_q.entry_total;

endmodule

[rtl/stf_ram.sv]
module stf_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/stf_ctrl.sv]
module stf_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic [stf_pkg::KIND_W-1:0]       req_kind_i,
  input  logic signed [stf_pkg::KEY_W-1:0] req_value_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output stf_pkg::stf_rsp_t                res_o,
  output stf_pkg::stf_mem_cmd_t            mem_o,
  input  logic signed [stf_pkg::KEY_W-1:0] mem_rdata_i
);
  import stf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_LAST,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DEL_SHL,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic                    del_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        lo_q;
  logic [CNT_W-1:0]        hi_q;
  logic [CNT_W-1:0]        idx_q;
  logic [IDX_W-1:0]        mid_q;
  logic [IDX_W-1:0]        at_q;
  stf_rsp_t                res_q;

  logic                    accept;
  logic [CNT_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid;
  logic [CNT_W-1:0]        lo_nx;
  logic [CNT_W-1:0]        hi_nx;
  logic [CNT_W-1:0]        mid_ext;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W-1:0]        cnt_dec;
  logic                    full;

  assign accept      = req_valid_i && (state_q == S_IDLE);
  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign full        = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign cnt_inc     = cnt_q + CNT_W'(1);
  assign cnt_dec     = cnt_q - CNT_W'(1);

  // floor((low + high) / 2) with high = hi - 1; lo < hi so the sum is never negative
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
  assign mid     = mid_sum[IDX_W:1];
  assign mid_ext = CNT_W'(mid_q);
  assign lo_nx   = mid_ext + CNT_W'(1);
  assign hi_nx   = mid_ext;

  always_comb begin
    mem_o       = '0;
    mem_o.wdata = key_q;
    case (state_q)
      S_IDLE: begin
        if (accept && req_kind_i == KIND_INSERT && !full && cnt_q != '0) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = cnt_dec[IDX_W-1:0];
        end
      end
      S_INS_CMP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = idx_q[IDX_W-1:0];
        if (mem_rdata_i > key_q) begin
          mem_o.wdata = mem_rdata_i;
          if (idx_q != CNT_W'(1)) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = IDX_W'(idx_q - CNT_W'(2));
          end
        end
      end
      S_INS_LAST: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = idx_q[IDX_W-1:0];
      end
      S_SRCH_RD: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = mid;
      end
      S_SRCH_CMP: begin
        if (mem_rdata_i == key_q && del_q && lo_nx < cnt_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = lo_nx[IDX_W-1:0];
        end
      end
      S_DEL_SHL: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = IDX_W'(idx_q - CNT_W'(1));
        mem_o.wdata = mem_rdata_i;
        if (idx_q + CNT_W'(1) < cnt_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = IDX_W'(idx_q + CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      del_q   <= 1'b0;
      key_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      idx_q   <= '0;
      mid_q   <= '0;
      at_q    <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            key_q <= req_value_i;
            del_q <= (req_kind_i == KIND_DELETE);
            lo_q  <= '0;
            hi_q  <= cnt_q;
            idx_q <= cnt_q;
            case (req_kind_i)
              KIND_INSERT: begin
                if (full) begin
                  res_q   <= '{ST_FULL, '0, TOTAL_W'(cnt_q)};
                  state_q <= S_DONE;
                end else if (cnt_q == '0) begin
                  state_q <= S_INS_LAST;
                end else begin
                  state_q <= S_INS_CMP;
                end
              end
              KIND_FIND, KIND_DELETE: begin
                if (cnt_q == '0) begin
                  res_q   <= '{ST_MISSING, '0, TOTAL_W'(cnt_q)};
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_SRCH_RD;
                end
              end
              default: begin
                res_q   <= '{ST_MISSING, '0, TOTAL_W'(cnt_q)};
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_INS_CMP: begin
          if (mem_rdata_i > key_q) begin
            idx_q <= idx_q - CNT_W'(1);
            if (idx_q == CNT_W'(1)) begin
              state_q <= S_INS_LAST;
            end
          end else begin
            cnt_q   <= cnt_inc;
            res_q   <= '{ST_DONE, POS_W'(idx_q), TOTAL_W'(cnt_inc)};
            state_q <= S_DONE;
          end
        end
        S_INS_LAST: begin
          cnt_q   <= cnt_inc;
          res_q   <= '{ST_DONE, POS_W'(idx_q), TOTAL_W'(cnt_inc)};
          state_q <= S_DONE;
        end
        S_SRCH_RD: begin
          mid_q   <= mid;
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (mem_rdata_i == key_q) begin
            if (!del_q) begin
              res_q   <= '{ST_DONE, POS_W'(mid_q), TOTAL_W'(cnt_q)};
              state_q <= S_DONE;
            end else if (lo_nx < cnt_q) begin
              at_q    <= mid_q;
              idx_q   <= lo_nx;
              state_q <= S_DEL_SHL;
            end else begin
              cnt_q   <= cnt_dec;
              res_q   <= '{ST_DONE, POS_W'(mid_q), TOTAL_W'(cnt_dec)};
              state_q <= S_DONE;
            end
          end else begin
            if (mem_rdata_i < key_q) begin
              lo_q <= lo_nx;
            end else begin
              hi_q <= hi_nx;
            end
            if ((mem_rdata_i < key_q) ? (lo_nx < hi_q) : (lo_q < hi_nx)) begin
              state_q <= S_SRCH_RD;
            end else begin
              res_q   <= '{ST_MISSING, '0, TOTAL_W'(cnt_q)};
              state_q <= S_DONE;
            end
          end
        end
        S_DEL_SHL: begin
          if (idx_q + CNT_W'(1) < cnt_q) begin
            idx_q <= idx_q + CNT_W'(1);
          end else begin
            cnt_q   <= cnt_dec;
            res_q   <= '{ST_DONE, POS_W'(at_q), TOTAL_W'(cnt_dec)};
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Fill level stays within the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Count moves by at most one per cycle
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1)) ||
             (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("entry count jumped");

  // Shifting never reads the entry it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_o.we && mem_o.re) |-> (mem_o.waddr != mem_o.raddr))
    else $error("read and write to the same entry");

  // Search window is never empty when a probe is issued
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_RD) |-> (lo_q < hi_q) && (hi_q <= cnt_q))
    else $error("empty search window probed");

  // Table is only changed while an operation is under way
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !mem_o.we)
    else $error("table written while idle");

endmodule

[test/testbench.sv]
module testbench;
  import stf_pkg::*;

  // Code 3 is not a defined request kind; the block must answer it as a miss
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 400;     // long response hold-off
  localparam int DRAIN_CYCLES = 40;      // margin after the worst request, including the output stage
  localparam int LIMIT_CYCLES = 600000;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps a mirror of the sorted table, works out the response of
  // every accepted request and holds it until the block answers.
  // --------------------------------------------------------------------------
  class table_scoreboard;
    logic signed [KEY_W-1:0] mirror_keys[TABLE_DEPTH];
    int                      mirror_fill;
    stf_rsp_t                awaited_responses[$];
    int                      errors;
    int                      hits, misses, full_drops, fill_peak;

    function new();
      mirror_fill = 0;
      errors      = 0;
      hits        = 0;
      misses      = 0;
      full_drops  = 0;
      fill_peak   = 0;
    endfunction

    function int pending();
      return awaited_responses.size();
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic signed [KEY_W-1:0] value);
      stf_rsp_t rsp;
      int       slot, lo, hi, mid;
      bit       hit;
      rsp.status   = ST_MISSING;
      rsp.position = '0;
      hit          = 1'b0;
      slot         = 0;
      case (kind)
        KIND_INSERT: begin
          if (mirror_fill >= TABLE_DEPTH) begin
            rsp.status = ST_FULL;
            full_drops++;
          end else begin
            // Larger keys move right; equal keys stay in front of the new one
            slot = mirror_fill;
            while (slot > 0 && mirror_keys[slot-1] > value) begin
              mirror_keys[slot] = mirror_keys[slot-1];
              slot--;
            end
            mirror_keys[slot] = value;
            mirror_fill++;
            rsp.status   = ST_DONE;
            rsp.position = POS_W'(slot);
          end
        end
        KIND_FIND, KIND_DELETE: begin
          // Binary search, floor midpoint, over every occupied entry
          lo = 0;
          hi = mirror_fill - 1;
          while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if (mirror_keys[mid] == value) begin
              hit  = 1'b1;
              slot = mid;
            end else if (mirror_keys[mid] < value) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
          if (hit) begin
            if (kind == KIND_DELETE) begin
              for (int i = slot + 1; i < mirror_fill; i++) mirror_keys[i-1] = mirror_keys[i];
              mirror_fill--;
            end
            rsp.status   = ST_DONE;
            rsp.position = POS_W'(slot);
            hits++;
          end else begin
            misses++;
          end
        end
        default: ;
      endcase
      if (mirror_fill > fill_peak) fill_peak = mirror_fill;
      rsp.entry_total = TOTAL_W'(mirror_fill);
      awaited_responses.push_back(rsp);
    endfunction

    function void check_response(stf_rsp_t got);
      stf_rsp_t want;
      if (awaited_responses.size() == 0) begin
        $error("response with nothing outstanding: status %0d position %0d total %0d",
               got.status, got.position, got.entry_total);
        errors++;
        return;
      end
      want = awaited_responses.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.entry_total !== want.entry_total) begin
        $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
        errors++;
      end
    endfunction
  endclass

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] value;
  } table_op_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  stf_req_if req_bus ();
  stf_rsp_if rsp_bus ();

  sorted_table_insert_find_delete DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  table_scoreboard sb;

  // Set by the stimulus, served and cleared by the response side
  bit hold_rsp = 1'b0;
  int holds_done = 0;

  // Keys recently inserted, so finds and deletes hit often
  logic signed [KEY_W-1:0] recent_keys[$];

  int cycle_count = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run-time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Monitor: both channels are sampled at the edge, before any update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) sb.note_request(req_bus.kind, req_bus.value);
      if (rsp_bus.valid && rsp_bus.ready) begin
        sb.check_response('{status: rsp_bus.status, position: rsp_bus.position,
                            entry_total: rsp_bus.entry_total});
      end
    end
  end

  // Response side: random ready with short and long dips, stretches held high,
  // and a long hold-off whenever the stimulus asks for one.
  initial begin
    int roll, dwell;
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rsp = 1'b0;
        holds_done++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          rsp_bus.ready <= 1'b1;
          dwell = $urandom_range(20, 60);
        end else if (roll < 60) begin
          rsp_bus.ready <= 1'b1;
          dwell = $urandom_range(1, 8);
        end else if (roll < 92) begin
          rsp_bus.ready <= 1'b0;
          dwell = $urandom_range(1, 3);
        end else begin
          rsp_bus.ready <= 1'b0;
          dwell = $urandom_range(10, 40);
        end
        repeat (dwell) @(posedge clk_i);
      end
    end
  end

  // Hold the request up until the block takes it
  task automatic offer_request(input logic [KIND_W-1:0] k, input logic signed [KEY_W-1:0] v);
    req_bus.valid <= 1'b1;
    req_bus.kind  <= k;
    req_bus.value <= v;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // Sender gap: usually none or a short one, now and then a long one
  task automatic request_gap();
    int roll, len;
    roll = $urandom_range(0, 99);
    if (roll < 50) len = 0;
    else if (roll < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 40);
    if (len > 0) begin
      req_bus.valid <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // Key choice: recent inserts, a small clustered range for duplicates,
  // the extremes, and fully random words for the rest.
  function automatic logic signed [KEY_W-1:0] pick_key(logic [KIND_W-1:0] k);
    int roll, at;
    logic signed [KEY_W-1:0] key;
    roll = $urandom_range(0, 99);
    if (k != KIND_INSERT && roll < 55 && recent_keys.size() > 0) begin
      at  = $urandom_range(0, recent_keys.size() - 1);
      key = recent_keys[at];
      if (k == KIND_DELETE) recent_keys.delete(at);
    end else if (roll < 75) begin
      key = $signed($urandom_range(0, 15)) - 8;
    end else if (roll < 82) begin
      case ($urandom_range(0, 3))
        0:       key = KEY_MIN;
        1:       key = KEY_MAX;
        2:       key = '0;
        default: key = '1;
      endcase
    end else begin
      key = $urandom;
    end
    return key;
  endfunction

  initial begin
    table_op_t opening[] = '{
      '{KIND_FIND, 5},   '{KIND_DELETE, 5},   '{KIND_UNUSED, 0},
      '{KIND_INSERT, KEY_MAX}, '{KIND_INSERT, KEY_MIN}, '{KIND_INSERT, 0},
      '{KIND_INSERT, -1}, '{KIND_INSERT, 5},  '{KIND_INSERT, 5}, '{KIND_INSERT, 5},
      '{KIND_FIND, 5},   '{KIND_FIND, KEY_MIN}, '{KIND_FIND, KEY_MAX}, '{KIND_FIND, 6},
      '{KIND_DELETE, 5}, '{KIND_DELETE, KEY_MIN}, '{KIND_DELETE, KEY_MAX},
      '{KIND_DELETE, 9}, '{KIND_UNUSED, -1},  '{KIND_FIND, -1}
    };
    logic [KIND_W-1:0]       k;
    logic signed [KEY_W-1:0] v;
    int  sent, epoch_len, roll;
    bit  filling, quiet;

    sb = new();
    rst_ni        <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.kind  <= KIND_INSERT;
    req_bus.value <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: empty table, unused kind, extremes, duplicates, misses
    foreach (opening[i]) begin
      offer_request(opening[i].kind, opening[i].value);
      request_gap();
    end

    // Random part in epochs that alternately fill (up to full, with drops)
    // and drain the table; some epochs run back to back with no gaps.
    sent    = 0;
    filling = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      epoch_len = $urandom_range(20, 50);
      filling   = !filling;
      quiet     = ($urandom_range(0, 3) == 0);
      repeat (epoch_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) k = KIND_UNUSED;
        else if (filling) k = (roll < 64) ? KIND_INSERT : (roll < 80) ? KIND_FIND : KIND_DELETE;
        else k = (roll < 30) ? KIND_INSERT : (roll < 50) ? KIND_FIND : KIND_DELETE;
        if (k == KIND_UNUSED) v = $urandom;
        else v = pick_key(k);
        offer_request(k, v);
        if (k == KIND_INSERT) begin
          recent_keys.push_back(v);
          if (recent_keys.size() > 32) void'(recent_keys.pop_front());
        end
        if (k != KIND_UNUSED) begin
          sent++;
          // Starve the response side twice while requests keep coming
          if (sent == 400 || sent == 1000) hold_rsp = 1'b1;
        end
        if (!quiet) request_gap();
      end
    end
    req_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d operations after the opening set: %0d search hits, %0d misses",
             sent, sb.hits, sb.misses);
    $display("%0d inserts dropped on a full table, peak fill %0d, %0d long response stalls",
             sb.full_drops, sb.fill_peak, holds_done);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/stf_pkg.sv
rtl/stf_if.sv
rtl/stf_ram.sv
rtl/stf_ctrl.sv
rtl/sorted_table_insert_find_delete.sv
test/testbench.sv
